// ===== sv/trs_aff_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_aff_pkg
// Types and constants shared by the rotation/scale/translation matrix pipeline.
// ----------------------------------------------------------------------------
package trs_aff_pkg;

   localparam int QUAT_W  = 16;
   localparam int WORD_W  = 32;
   localparam int QPROD_W = 2 * QUAT_W;
   localparam int ROT_W   = 34;
   localparam int PROD_W  = ROT_W + WORD_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int FRAC_SH = 30;
   localparam int NUM_TERMS = 9;

   // 1.0 in Q.30
   localparam logic signed [ROT_W-1:0] ONE_Q30 = {{(ROT_W-FRAC_SH-1){1'b0}}, 1'b1,
                                                  {FRAC_SH{1'b0}}};
   // half an lsb of the Q16.16 result
   localparam logic signed [SUM_W-1:0] ROUND_Q30 = {{(SUM_W-FRAC_SH){1'b0}}, 1'b1,
                                                    {(FRAC_SH-1){1'b0}}};

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [WORD_W-1:0] scale_x;
      logic signed [WORD_W-1:0] scale_y;
      logic signed [WORD_W-1:0] scale_z;
      logic signed [WORD_W-1:0] shift_x;
      logic signed [WORD_W-1:0] shift_y;
      logic signed [WORD_W-1:0] shift_z;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] m00;
      logic signed [WORD_W-1:0] m10;
      logic signed [WORD_W-1:0] m20;
      logic signed [WORD_W-1:0] m01;
      logic signed [WORD_W-1:0] m11;
      logic signed [WORD_W-1:0] m21;
      logic signed [WORD_W-1:0] m02;
      logic signed [WORD_W-1:0] m12;
      logic signed [WORD_W-1:0] m22;
      logic signed [WORD_W-1:0] out_shift_x;
      logic signed [WORD_W-1:0] out_shift_y;
      logic signed [WORD_W-1:0] out_shift_z;
   } rsp_type;

   typedef struct packed {
      logic signed [QPROD_W-1:0] xx;
      logic signed [QPROD_W-1:0] yy;
      logic signed [QPROD_W-1:0] zz;
      logic signed [QPROD_W-1:0] xy;
      logic signed [QPROD_W-1:0] xz;
      logic signed [QPROD_W-1:0] yz;
      logic signed [QPROD_W-1:0] wx;
      logic signed [QPROD_W-1:0] wy;
      logic signed [QPROD_W-1:0] wz;
      logic [2:0][WORD_W-1:0]    scale;
      logic [2:0][WORD_W-1:0]    shift;
   } qprod_stage_type;

   // terms in output order: m00 m10 m20 m01 m11 m21 m02 m12 m22
   typedef struct packed {
      logic [NUM_TERMS-1:0][ROT_W-1:0] rot;
      logic [2:0][WORD_W-1:0]          scale;
      logic [2:0][WORD_W-1:0]          shift;
   } rot_stage_type;

   typedef struct packed {
      logic [NUM_TERMS-1:0][PROD_W-1:0] prod;
      logic [2:0][WORD_W-1:0]           shift;
   } mul_stage_type;

endpackage

// ===== sv/trs_to_affine_matrix_unit.sv =====
// throughput: one item per cycle unless the output stalls, set by four
// register stages (quaternion products, rotation terms, scale multiply,
// round and saturate)
// a stage moves on whenever the stage after it is empty or draining
// reset clears the stage valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
// trs_to_affine_matrix_unit
// Rotation quaternion, scale and translation to a scaled 3x4 affine matrix.
// ----------------------------------------------------------------------------
module trs_to_affine_matrix_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  trs_aff_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output trs_aff_pkg::rsp_type  rsp_data
);

   logic                          s1_valid;
   logic                          s1_ready;
   trs_aff_pkg::qprod_stage_type  s1_data;
   logic                          s2_valid;
   logic                          s2_ready;
   trs_aff_pkg::rot_stage_type    s2_data;
   logic                          s3_valid;
   logic                          s3_ready;
   trs_aff_pkg::mul_stage_type    s3_data;

   trs_aff_quat_prod u_quat_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   trs_aff_rot_terms u_rot_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   trs_aff_scale_mul u_scale_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   trs_aff_round_sat u_round_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef SYNTH
   // an unstalled output means the whole pipe advances
   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline blocks input while output is free");

   // an accepted item occupies the first stage on the next edge
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid)
      else $error("accepted item lost at first stage");

   // a stalled stage keeps its item
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (s3_valid && !s3_ready) |=> s3_valid && $stable(s3_data))
      else $error("stalled multiply stage dropped or changed its item");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid && !s2_valid && !s3_valid)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== sv/trs_aff_quat_prod.sv =====
// ----------------------------------------------------------------------------
// trs_aff_quat_prod
// First stage: the nine quaternion component products, exact in Q2.30.
// ----------------------------------------------------------------------------
module trs_aff_quat_prod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  trs_aff_pkg::req_type          in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output trs_aff_pkg::qprod_stage_type  out_data
);

   logic                          valid_ff;
   trs_aff_pkg::qprod_stage_type  data_ff;
   trs_aff_pkg::qprod_stage_type  data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.xx = in_data.quat_x * in_data.quat_x;
      data_in.yy = in_data.quat_y * in_data.quat_y;
      data_in.zz = in_data.quat_z * in_data.quat_z;
      data_in.xy = in_data.quat_x * in_data.quat_y;
      data_in.xz = in_data.quat_x * in_data.quat_z;
      data_in.yz = in_data.quat_y * in_data.quat_z;
      data_in.wx = in_data.quat_w * in_data.quat_x;
      data_in.wy = in_data.quat_w * in_data.quat_y;
      data_in.wz = in_data.quat_w * in_data.quat_z;
      data_in.scale[0] = in_data.scale_x;
      data_in.scale[1] = in_data.scale_y;
      data_in.scale[2] = in_data.scale_z;
      data_in.shift[0] = in_data.shift_x;
      data_in.shift[1] = in_data.shift_y;
      data_in.shift[2] = in_data.shift_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/trs_aff_rot_terms.sv =====
// ----------------------------------------------------------------------------
// trs_aff_rot_terms
// Second stage: the nine rotation matrix terms in Q.30.
// ----------------------------------------------------------------------------
module trs_aff_rot_terms (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  trs_aff_pkg::qprod_stage_type  in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output trs_aff_pkg::rot_stage_type    out_data
);

   logic                        valid_ff;
   trs_aff_pkg::rot_stage_type  data_ff;
   trs_aff_pkg::rot_stage_type  data_in;

   // 1 - 2*(p + q)
   function automatic logic signed [trs_aff_pkg::ROT_W-1:0] diag_term(
      input logic signed [trs_aff_pkg::QPROD_W-1:0] p,
      input logic signed [trs_aff_pkg::QPROD_W-1:0] q
   );
      logic signed [trs_aff_pkg::ROT_W-1:0] s;
      s = trs_aff_pkg::ROT_W'(p) + trs_aff_pkg::ROT_W'(q);
      return trs_aff_pkg::ONE_Q30 - (s <<< 1);
   endfunction

   // 2*(p + q) or 2*(p - q)
   function automatic logic signed [trs_aff_pkg::ROT_W-1:0] cross_term(
      input logic signed [trs_aff_pkg::QPROD_W-1:0] p,
      input logic signed [trs_aff_pkg::QPROD_W-1:0] q,
      input logic                                   sub
   );
      logic signed [trs_aff_pkg::ROT_W-1:0] s;
      if (sub) begin
         s = trs_aff_pkg::ROT_W'(p) - trs_aff_pkg::ROT_W'(q);
      end else begin
         s = trs_aff_pkg::ROT_W'(p) + trs_aff_pkg::ROT_W'(q);
      end
      return s <<< 1;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in.rot[0] = diag_term(in_data.yy, in_data.zz);
      data_in.rot[1] = cross_term(in_data.xy, in_data.wz, 1'b0);
      data_in.rot[2] = cross_term(in_data.xz, in_data.wy, 1'b1);
      data_in.rot[3] = cross_term(in_data.xy, in_data.wz, 1'b1);
      data_in.rot[4] = diag_term(in_data.xx, in_data.zz);
      data_in.rot[5] = cross_term(in_data.yz, in_data.wx, 1'b0);
      data_in.rot[6] = cross_term(in_data.xz, in_data.wy, 1'b0);
      data_in.rot[7] = cross_term(in_data.yz, in_data.wx, 1'b1);
      data_in.rot[8] = diag_term(in_data.xx, in_data.yy);
      data_in.scale  = in_data.scale;
      data_in.shift  = in_data.shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/trs_aff_scale_mul.sv =====
// ----------------------------------------------------------------------------
// trs_aff_scale_mul
// Third stage: each rotation term times its column's scale, exact in Q.46.
// ----------------------------------------------------------------------------
module trs_aff_scale_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  trs_aff_pkg::rot_stage_type  in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output trs_aff_pkg::mul_stage_type  out_data
);

   logic                        valid_ff;
   trs_aff_pkg::mul_stage_type  data_ff;
   trs_aff_pkg::mul_stage_type  data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < trs_aff_pkg::NUM_TERMS; i++) begin
         // column i/3 takes scale x, y or z
         data_in.prod[i] = $signed(in_data.rot[i]) * $signed(in_data.scale[i/3]);
      end
      data_in.shift = in_data.shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/trs_aff_round_sat.sv =====
// ----------------------------------------------------------------------------
// trs_aff_round_sat
// Last stage: round half up to Q16.16, saturate, and hold the result item.
// ----------------------------------------------------------------------------
module trs_aff_round_sat (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  trs_aff_pkg::mul_stage_type  in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output trs_aff_pkg::rsp_type        out_data
);

   localparam int Q_W = trs_aff_pkg::SUM_W - trs_aff_pkg::FRAC_SH;
   localparam int W   = trs_aff_pkg::WORD_W;

   logic                                 valid_ff;
   trs_aff_pkg::rsp_type                 data_ff;
   trs_aff_pkg::rsp_type                 data_in;
   logic [trs_aff_pkg::NUM_TERMS-1:0][W-1:0] term;

   function automatic logic [W-1:0] round_sat(
      input logic [trs_aff_pkg::PROD_W-1:0] prod
   );
      logic signed [trs_aff_pkg::SUM_W-1:0] sum;
      logic signed [trs_aff_pkg::SUM_W-1:0] shifted;
      logic signed [Q_W-1:0]                 q;
      logic [W-1:0]                          res;
      sum     = trs_aff_pkg::SUM_W'($signed(prod)) + trs_aff_pkg::ROUND_Q30;
      shifted = sum >>> trs_aff_pkg::FRAC_SH;
      q       = shifted[Q_W-1:0];
      // in range when all bits above the result's sign agree with it
      if (q[Q_W-1:W-1] == {(Q_W-W+1){q[W-1]}}) begin
         res = q[W-1:0];
      end else if (q[Q_W-1]) begin
         res = {1'b1, {(W-1){1'b0}}};
      end else begin
         res = {1'b0, {(W-1){1'b1}}};
      end
      return res;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < trs_aff_pkg::NUM_TERMS; i++) begin
         term[i] = round_sat(in_data.prod[i]);
      end
      data_in.m00 = term[0];
      data_in.m10 = term[1];
      data_in.m20 = term[2];
      data_in.m01 = term[3];
      data_in.m11 = term[4];
      data_in.m21 = term[5];
      data_in.m02 = term[6];
      data_in.m12 = term[7];
      data_in.m22 = term[8];
      data_in.out_shift_x = in_data.shift[0];
      data_in.out_shift_y = in_data.shift[1];
      data_in.out_shift_z = in_data.shift[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== tb/tb_trs_to_affine_matrix_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trs_to_affine_matrix_unit
// Drives rotation/scale/translation items into the matrix pipeline under
// random sender bursts and receiver stalls, and checks every returned matrix
// against a fixed-point model of the scaled rotation with rounding and
// saturation.
// ----------------------------------------------------------------------------
module tb_trs_to_affine_matrix_unit;

   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     RSP_LATENCY  = 4;
   localparam int     RANDOM_CHUNK = 400;
   localparam int     CHUNK_COUNT  = 4;
   localparam int     Q16_ONE      = 65536;
   localparam int     WORD_MAX     = 32'h7FFF_FFFF;
   localparam int     WORD_MIN     = 32'h8000_0000;
   localparam int     QUAT_MAX     = 32767;
   localparam int     QUAT_MIN     = -32768;
   localparam int     QUAT_HALF_RT = 23170;
   localparam int     QUAT_HALF    = 16384;
   localparam longint UNIT_Q30     = 64'sd1 <<< trs_aff_pkg::FRAC_SH;
   localparam longint HALF_LSB     = 64'sd1 <<< (trs_aff_pkg::FRAC_SH - 1);
   localparam longint SAT_HI       = 64'sh7FFF_FFFF;
   localparam longint SAT_LO       = -64'sh8000_0000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   trs_aff_pkg::req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   trs_aff_pkg::rsp_type rsp_data;

   trs_aff_pkg::req_type transform_queue[$];
   trs_aff_pkg::rsp_type matrix_expected[$];

   int cycle_count     = 0;
   int mismatch_count  = 0;
   int transforms_sent = 0;
   int matrices_seen   = 0;
   int saturated_terms = 0;
   int directed_count  = 0;

   trs_to_affine_matrix_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // rotation term in q.30 times q16.16 scale, rounded half up to q16.16 and saturated
   function automatic logic signed [trs_aff_pkg::WORD_W-1:0] scale_round_sat(
      longint rot,
      longint scl
   );
      longint prod;
      longint rounded;
      prod    = rot * scl;
      rounded = (prod + HALF_LSB) >>> trs_aff_pkg::FRAC_SH;
      if (rounded > SAT_HI) begin
         rounded = SAT_HI;
      end else if (rounded < SAT_LO) begin
         rounded = SAT_LO;
      end
      return rounded[trs_aff_pkg::WORD_W-1:0];
   endfunction

   function automatic trs_aff_pkg::rsp_type scaled_matrix(trs_aff_pkg::req_type t);
      trs_aff_pkg::rsp_type m;
      longint  qx, qy, qz, qw, sx, sy, sz;
      longint  xx, yy, zz, xy, xz, yz, wx, wy, wz;
      qx = t.quat_x;
      qy = t.quat_y;
      qz = t.quat_z;
      qw = t.quat_w;
      sx = t.scale_x;
      sy = t.scale_y;
      sz = t.scale_z;
      xx = qx * qx;
      yy = qy * qy;
      zz = qz * qz;
      xy = qx * qy;
      xz = qx * qz;
      yz = qy * qz;
      wx = qw * qx;
      wy = qw * qy;
      wz = qw * qz;
      m.m00 = scale_round_sat(UNIT_Q30 - 2 * (yy + zz), sx);
      m.m10 = scale_round_sat(2 * (xy + wz), sx);
      m.m20 = scale_round_sat(2 * (xz - wy), sx);
      m.m01 = scale_round_sat(2 * (xy - wz), sy);
      m.m11 = scale_round_sat(UNIT_Q30 - 2 * (xx + zz), sy);
      m.m21 = scale_round_sat(2 * (yz + wx), sy);
      m.m02 = scale_round_sat(2 * (xz + wy), sz);
      m.m12 = scale_round_sat(2 * (yz - wx), sz);
      m.m22 = scale_round_sat(UNIT_Q30 - 2 * (xx + yy), sz);
      m.out_shift_x = t.shift_x;
      m.out_shift_y = t.shift_y;
      m.out_shift_z = t.shift_z;
      return m;
   endfunction

   function automatic trs_aff_pkg::req_type make_transform(int qx, int qy, int qz, int qw,
                                                           int sx, int sy, int sz,
                                                           int tx, int ty, int tz);
      trs_aff_pkg::req_type t;
      t.quat_x  = 16'(qx);
      t.quat_y  = 16'(qy);
      t.quat_z  = 16'(qz);
      t.quat_w  = 16'(qw);
      t.scale_x = sx;
      t.scale_y = sy;
      t.scale_z = sz;
      t.shift_x = tx;
      t.shift_y = ty;
      t.shift_z = tz;
      return t;
   endfunction

   function automatic void add_transform(trs_aff_pkg::req_type t);
      transform_queue.insert(transform_queue.size(), t);
   endfunction

   function automatic int pick_scale();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         return int'($urandom_range(0, 1 << 20)) - (1 << 19);
      end else if (sel == 6) begin
         return $urandom();
      end else if (sel == 7) begin
         return $urandom_range(0, 1) ? Q16_ONE : -Q16_ONE;
      end else if (sel == 8) begin
         case ($urandom_range(0, 3))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 0;
            default: return -1;
         endcase
      end
      return int'($urandom_range(0, 1 << 25)) - (1 << 24);
   endfunction

   // mostly near-unit quaternions, the rest raw bit patterns
   function automatic trs_aff_pkg::req_type random_transform();
      trs_aff_pkg::req_type t;
      real     v [4];
      real     norm;
      int      i;
      t.scale_x = pick_scale();
      t.scale_y = pick_scale();
      t.scale_z = pick_scale();
      t.shift_x = $urandom();
      t.shift_y = $urandom();
      t.shift_z = $urandom();
      if ($urandom_range(0, 9) < 7) begin
         do begin
            norm = 0.0;
            for (i = 0; i < 4; i++) begin
               v[i] = real'(int'($urandom_range(0, 65534)) - 32767);
               norm = norm + v[i] * v[i];
            end
         end while (norm < 1.0e6);
         norm = $sqrt(norm);
         t.quat_x = 16'($rtoi(v[0] * 32767.0 / norm));
         t.quat_y = 16'($rtoi(v[1] * 32767.0 / norm));
         t.quat_z = 16'($rtoi(v[2] * 32767.0 / norm));
         t.quat_w = 16'($rtoi(v[3] * 32767.0 / norm));
      end else begin
         {t.quat_x, t.quat_y, t.quat_z, t.quat_w} = {$urandom(), $urandom()};
         t.scale_x = $urandom();
         t.scale_y = $urandom();
         t.scale_z = $urandom();
      end
      return t;
   endfunction

   // sampled away from the rising edge so the sender and checker have settled
   task automatic wait_drained();
      while (transform_queue.size() > 0 || req_valid || matrix_expected.size() > 0) begin
         @(negedge clock);
      end
   endtask

   // sender: bursts of items separated by random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            matrix_expected.insert(matrix_expected.size(), scaled_matrix(req_data));
            transforms_sent++;
         end
         if (!req_valid || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (transform_queue.size() > 0) begin
               req_data  <= transform_queue.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     3, 4, 5: gap_left = $urandom_range(1, 4);
                     6:       gap_left = $urandom_range(5, 12);
                     default: gap_left = $urandom_range(13, 40);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern switches between free running, random and periodic
   string term_name [12] = '{"m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22",
                             "out_shift_x", "out_shift_y", "out_shift_z"};
   int stall_mode  = 0;
   int stall_left  = 0;
   int stall_phase = 0;

   always @(posedge clock) begin
      trs_aff_pkg::rsp_type                 want;
      logic [11:0][trs_aff_pkg::WORD_W-1:0] want_w;
      logic [11:0][trs_aff_pkg::WORD_W-1:0] got_w;
      int                                   i;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            matrices_seen++;
            if (matrix_expected.size() == 0) begin
               $error("matrix received with no transform outstanding: %h", rsp_data);
               mismatch_count++;
            end else begin
               want   = matrix_expected.pop_front();
               want_w = want;
               got_w  = rsp_data;
               for (i = 0; i < 12; i++) begin
                  if (got_w[11-i] !== want_w[11-i]) begin
                     $error("%s: expected %h, got %h", term_name[i], want_w[11-i],
                            got_w[11-i]);
                     mismatch_count++;
                  end
                  if (i < 9 && (want_w[11-i] == WORD_MAX || want_w[11-i] == WORD_MIN)) begin
                     saturated_terms++;
                  end
               end
            end
         end
         if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 300);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_phase % 7) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_trs_to_affine_matrix_unit: FAIL");
         $finish;
      end
   end

   initial begin
      int chunk;
      int n;
      // identity, both signs of w
      add_transform(make_transform(0, 0, 0, QUAT_MAX, Q16_ONE, Q16_ONE, Q16_ONE,
                                   0, 0, 0));
      add_transform(make_transform(0, 0, 0, QUAT_MIN, Q16_ONE, Q16_ONE, Q16_ONE,
                                   WORD_MAX, WORD_MIN, -1));
      // quarter turns about each axis
      add_transform(make_transform(QUAT_HALF_RT, 0, 0, QUAT_HALF_RT,
                                   Q16_ONE, 2 * Q16_ONE, -Q16_ONE, Q16_ONE, 2, 3));
      add_transform(make_transform(0, QUAT_HALF_RT, 0, QUAT_HALF_RT,
                                   -Q16_ONE, Q16_ONE, 2 * Q16_ONE, -5, 0, 7));
      add_transform(make_transform(0, 0, QUAT_HALF_RT, QUAT_HALF_RT,
                                   2 * Q16_ONE, -Q16_ONE, Q16_ONE, 0, -9, 1));
      // half turns at -1.0 components
      add_transform(make_transform(QUAT_MIN, 0, 0, 0, Q16_ONE, Q16_ONE, Q16_ONE,
                                   0, 0, 0));
      add_transform(make_transform(0, QUAT_MIN, 0, 0, WORD_MAX, WORD_MAX,
                                   WORD_MAX, 1, 1, 1));
      add_transform(make_transform(0, 0, QUAT_MIN, 0, WORD_MIN, WORD_MIN,
                                   WORD_MIN, -1, -1, -1));
      // non-unit quaternions driving saturation both ways
      add_transform(make_transform(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN,
                                   WORD_MAX, WORD_MIN, WORD_MAX, 0, 0, 0));
      add_transform(make_transform(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX,
                                   WORD_MIN, WORD_MAX, WORD_MIN, 0, 0, 0));
      add_transform(make_transform(QUAT_MAX, QUAT_MIN, QUAT_MAX, QUAT_MIN,
                                   WORD_MAX, WORD_MIN, WORD_MAX,
                                   WORD_MIN, WORD_MAX, 0));
      add_transform(make_transform(0, 0, 0, 0, WORD_MIN, WORD_MAX, 0, 5, 6, 7));
      // exact half lsb products to check rounding direction
      add_transform(make_transform(0, 0, QUAT_HALF, 0, 1, -1, 1, 0, 0, 0));
      add_transform(make_transform(0, 0, QUAT_HALF, 0, -1, 1, -1, 0, 0, 0));
      add_transform(make_transform(QUAT_HALF, QUAT_HALF, QUAT_HALF, QUAT_HALF,
                                   3 * Q16_ONE, -5 * Q16_ONE, Q16_ONE / 2,
                                   100, -100, 1000));
      add_transform(make_transform(0, 0, 0, QUAT_MAX, 0, 0, 0,
                                   WORD_MAX, WORD_MAX, WORD_MAX));
      add_transform(make_transform(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      add_transform(make_transform(QUAT_MAX, 0, 0, 0, Q16_ONE, Q16_ONE, Q16_ONE,
                                   WORD_MIN, WORD_MIN, WORD_MIN));
      add_transform(make_transform(0, 0, 0, QUAT_MAX, WORD_MAX, WORD_MAX,
                                   WORD_MAX, 0, 0, 0));
      add_transform(make_transform(12345, -23456, 3210, -17000, 32'h1234_5678,
                                   -32'h0ABC_DEF0, 32'h00FF_00FF,
                                   32'h0F0F_0F0F, -32'h7070_7070, 32'h5A5A_A5A5));
      directed_count = transform_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender holds off until the pipeline has fully drained between chunks
      for (chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
         wait_drained();
         for (n = 0; n < RANDOM_CHUNK; n++) begin
            add_transform(random_transform());
         end
      end
      wait_drained();
      repeat (RSP_LATENCY * 4) @(posedge clock);

      $display("sent %0d transforms (%0d directed), checked %0d matrices in %0d cycles",
               transforms_sent, directed_count, matrices_seen, cycle_count);
      $display("saturated matrix terms seen: %0d, mismatches: %0d",
               saturated_terms, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_trs_to_affine_matrix_unit: PASS");
      end else begin
         $display("tb_trs_to_affine_matrix_unit: FAIL");
      end
      $finish;
   end

endmodule
